// ===== hdl/moving_average_filter_unit_defines.svh =====
// Assertion macros shared by the moving average filter RTL.
`ifndef MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define MAF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define MAF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define MAF_ASSERT(label, clk, rst, prop, msg)
`define MAF_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== hdl/maf_pkg.sv =====
// Shared constants and controller/datapath interface types for the moving average filter.
package maf_pkg;

   // Sizing
   localparam int MAX_WINDOW  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int WIN_BITS    = 5;
   localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
   localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int DIV_STEPS   = SUM_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_WINDOW_LEN = 3'h0;
   localparam logic [WIN_BITS-1:0]      WINDOW_RESET    = 5'd5;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // take the request sample, normalize the write slot
      logic read;      // read the oldest sample from the ring
      logic update;    // write the ring, update sum, count and slot
      logic div_load;  // load the divider with |sum|
      logic div_step;  // one restoring divide step
      logic load_out;  // load the output register
   } maf_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_last;  // current divide step is the final one
   } maf_status_type;

endpackage

// ===== hdl/moving_average_filter_unit.sv =====
// Top level of the moving average (boxcar) filter: stream ports, register port, assertions.
//
// Usage:
//   req channel carries one signed 16-bit sample per request; rsp channel returns
//   the mean of the last min(window_len, samples seen) samples, truncated toward zero.
//   One response per request, in order. The window is window_len clamped to 1..16.
//   The register port holds window_len at byte address 0 (reset value 5); writing it
//   clears the sample history, running sum and fill count. Write only while idle.
// Timing:
//   A request is accepted only while the controller is idle. It then passes through
//   the ring read, the sum update, the divider load and the bit-serial restoring
//   divider (one quotient bit per cycle), and then the response is loaded into the
//   output register. The next request is accepted the cycle after the load, so a new
//   request is not taken while the previous one is still in progress.
//   The output register holds a response while the receiver stalls; a finished result
//   waits for it before the next request is taken.
// Reset:
//   Synchronous, active high. Clears the controller, the output valid, the running
//   sum, fill count and write slot; window_len returns to 5.
`include "moving_average_filter_unit_defines.svh"

module moving_average_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [15:0] sample_in
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // [15:0] average_out
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [maf_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [maf_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import maf_pkg::*;

   maf_cmd_type            cmd;
   maf_status_type         status;
   logic                   cfg_wr;
   logic [WIN_BITS-1:0]    window_len;
   logic [SAMPLE_BITS-1:0] average_out;

   // Register access decode
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == ADDR_WINDOW_LEN);
   assign csr_prdata = (csr_paddr == ADDR_WINDOW_LEN) ? CSR_DATA_BITS'(window_len) : '0;

   maf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   maf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample_in   (req_tdata),
      .cfg_wr      (cfg_wr),
      .cfg_window  (csr_pwdata[WIN_BITS-1:0]),
      .window_len  (window_len),
      .average_out (average_out)
   );

   assign rsp_tdata = average_out;

   // Assertions
   `MAF_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "request accepted while previous one in progress")
   `MAF_ASSERT(a_valid_from_load, clock, reset, $rose(rsp_tvalid) |-> $past(cmd.load_out), "response valid without output load")
   `MAF_ASSERT_NEVER(a_load_while_idle, clock, reset, cmd.load_out && req_tready, "output loaded while idle")

endmodule

// ===== hdl/maf_datapath.sv =====
// Datapath: sample ring, running sum, fill count, serial divider and output register.
module maf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  maf_pkg::maf_cmd_type                 cmd,
   output maf_pkg::maf_status_type              status,
   input  logic [maf_pkg::SAMPLE_BITS-1:0]      sample_in,
   input  logic                                 cfg_wr,
   input  logic [maf_pkg::WIN_BITS-1:0]         cfg_window,
   output logic [maf_pkg::WIN_BITS-1:0]         window_len,
   output logic [maf_pkg::SAMPLE_BITS-1:0]      average_out
);
   import maf_pkg::*;

   // Sample history, no reset
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

   logic [WIN_BITS-1:0]           window_ff, window_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SLOT_BITS-1:0]          slot_ff, slot_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic [SUM_BITS-1:0]           quo_ff, quo_in;
   logic [CNT_BITS-1:0]           rem_ff, rem_in;
   logic                          neg_ff;
   logic [STEP_BITS-1:0]          step_ff;
   logic [SAMPLE_BITS-1:0]        avg_ff;

   logic [CNT_BITS-1:0]           eff_win;
   logic [CNT_BITS-1:0]           slot_ext;
   logic [CNT_BITS-1:0]           slot_inc;
   logic [SLOT_BITS-1:0]          slot_norm;
   logic                          full;
   logic signed [SUM_BITS-1:0]    sample_ext, old_ext;
   logic [SUM_BITS-1:0]           sum_mag;
   logic [CNT_BITS:0]             shifted;
   logic [CNT_BITS+1:0]           diff;
   logic                          ge;
   logic [SAMPLE_BITS-1:0]        quo_low;

   // Effective window: zero acts as one, clipped to the ring depth
   always_comb begin
      priority if (window_ff == '0) begin
         eff_win = CNT_BITS'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         eff_win = CNT_BITS'(MAX_WINDOW);
      end else begin
         eff_win = CNT_BITS'(window_ff);
      end
   end

   assign slot_ext  = CNT_BITS'(slot_ff);
   assign slot_norm = (slot_ext >= eff_win) ? '0 : slot_ff;
   assign slot_inc  = slot_ext + CNT_BITS'(1);
   assign full      = (count_ff >= eff_win);

   assign sample_ext = {{(SUM_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
   assign old_ext    = full ? {{(SUM_BITS-SAMPLE_BITS){old_ff[SAMPLE_BITS-1]}}, old_ff} : '0;
   assign sum_mag    = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);

   // Window register and history bookkeeping
   always_comb begin
      window_in = window_ff;
      sum_in    = sum_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      priority if (cfg_wr) begin
         window_in = cfg_window;
         sum_in    = '0;
         slot_in   = '0;
         count_in  = '0;
      end else if (cmd.capture) begin
         slot_in = slot_norm;
      end else if (cmd.update) begin
         sum_in   = sum_ff - old_ext + sample_ext;
         count_in = full ? eff_win : count_ff + CNT_BITS'(1);
         slot_in  = (slot_inc >= eff_win) ? '0 : slot_inc[SLOT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         sum_ff    <= '0;
         slot_ff   <= '0;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         sum_ff    <= sum_in;
         slot_ff   <= slot_in;
         count_ff  <= count_in;
      end
   end

   // Request sample capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample_in;
      end
   end

   // Ring memory: registered read of the oldest sample, write of the new one
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         old_ff <= ring_mem[slot_ff];
      end
      if (cmd.update) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   // One restoring divide step: magnitude of sum over fill count
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, count_ff};
   assign ge      = ~diff[CNT_BITS+1];
   assign rem_in  = ge ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
   assign quo_in  = {quo_ff[SUM_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         neg_ff  <= sum_ff[SUM_BITS-1];
         quo_ff  <= sum_mag;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   assign status.div_last = (step_ff == STEP_BITS'(DIV_STEPS - 1));

   // Output register, sign restored (truncation toward zero)
   assign quo_low = quo_ff[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff <= neg_ff ? SAMPLE_BITS'(-quo_low) : quo_low;
      end
   end

   assign average_out = avg_ff;
   assign window_len  = window_ff;

endmodule

// ===== hdl/maf_ctrl.sv =====
// Controller: sequences one request through ring access, sum update, divide and output.
module maf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output maf_pkg::maf_cmd_type    cmd,
   input  maf_pkg::maf_status_type status
);
   import maf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_DONE   = 6'b100000
   } maf_state_type;

   maf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared when taken
   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== tb/tb_moving_average_filter_unit.sv =====
// Self-checking testbench for the moving average filter: stream and register traffic.

class maf_scoreboard;
   logic signed [15:0] history [maf_pkg::MAX_WINDOW];
   int                 running_total;
   int unsigned        slot;
   int unsigned        filled;
   logic [4:0]         window_reg;
   logic signed [15:0] pending_means [$];
   int                 errors;

   function new();
      window_reg = maf_pkg::WINDOW_RESET;
      errors     = 0;
      clear_history();
   endfunction

   function void clear_history();
      foreach (history[i]) history[i] = '0;
      running_total = 0;
      slot          = 0;
      filled        = 0;
   endfunction

   // window_len write: new length, history starts over
   function void write_window(input logic [4:0] value);
      window_reg = value;
      clear_history();
   endfunction

   // accepted request: update the boxcar state and queue the expected mean
   function void note_sample(input logic signed [15:0] sample);
      int unsigned span;
      int          mean;
      span = (window_reg == 0) ? 1 :
             (window_reg > maf_pkg::MAX_WINDOW) ? maf_pkg::MAX_WINDOW : window_reg;
      if (slot >= span) slot = 0;
      if (filled >= span) begin
         running_total -= history[slot];
         filled = span;
      end else begin
         filled++;
      end
      history[slot] = sample;
      running_total += sample;
      slot++;
      if (slot >= span) slot = 0;
      // signed integer division truncates toward zero
      mean = running_total / int'(filled);
      pending_means.push_back(mean[15:0]);
   endfunction

   // accepted response: compare with the oldest expected mean
   function void check_mean(input logic [15:0] actual);
      logic signed [15:0] expected;
      if (pending_means.size() == 0) begin
         $error("average_out: no response expected, got %0d", $signed(actual));
         errors++;
      end else begin
         expected = pending_means.pop_front();
         if (actual !== expected) begin
            $error("average_out: expected %0d, actual %0d", expected, $signed(actual));
            errors++;
         end
      end
   endfunction
endclass

module tb_moving_average_filter_unit;
   import maf_pkg::*;

   localparam int                       CYCLE_LIMIT = 600000;
   localparam int                       IDLE_PCT    = 32;
   localparam int                       DRAIN_WAIT  = 40;
   localparam int                       HOLD_CYCLES = 300;
   localparam int                       HOLD_AFTER  = 400;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE  = 3'h4;
   localparam logic signed [15:0]       SAMPLE_MAX  = 16'h7fff;
   localparam logic signed [15:0]       SAMPLE_MIN  = 16'h8000;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [15:0]              req_tdata;   // [15:0] sample_in
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [15:0]              rsp_tdata;   // [15:0] average_out
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   maf_scoreboard sb = new();
   bit            quiet;
   int            mean_count;

   moving_average_filter_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clock);
      $display("moving_average_filter_unit: mismatch");
      $finish;
   end

   // monitor: both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            mean_count++;
            sb.check_mean(rsp_tdata);
         end
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && mean_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic signed [15:0] pick_sample();
      int unsigned        r;
      logic signed [15:0] value;
      r = $urandom_range(99);
      if (r < 50)      value = 16'($urandom);
      else if (r < 65) value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      else             value = 16'($urandom_range(16)) - 16'sd8;
      return value;
   endfunction

   // one request; valid stays high into the next request unless a gap is chosen
   task automatic send_sample(input logic signed [15:0] sample);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
   endtask

   // random requests, sometimes a run of one extreme to push the sum to its limits
   task automatic send_items(input int count);
      logic signed [15:0] value;
      int                 run;
      run = 0;
      for (int k = 0; k < count; k++) begin
         if (run == 0 && $urandom_range(19) == 0) begin
            run   = MAX_WINDOW;
            value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         end
         if (run > 0) run--;
         else value = pick_sample();
         send_sample(value);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_WINDOW_LEN) sb.write_window(data[4:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_BITS-1:0] addr,
                           output logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_window(input logic [4:0] expected);
      logic [CSR_DATA_BITS-1:0] value;
      csr_read(ADDR_WINDOW_LEN, value);
      if (value[4:0] !== expected) begin
         $error("window_len: expected %0d, actual %0d", expected, value[4:0]);
         sb.errors++;
      end
   endtask

   // block must be idle before a register write
   // it first waits for the monitor to count the last accepted request
   task automatic wait_idle();
      @(posedge clock);
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // new window length, upper write bits random, then read back
   task automatic set_window(input logic [4:0] length);
      logic [CSR_DATA_BITS-1:0] data;
      wait_idle();
      data = ($urandom & ~32'h1f) | length;
      csr_write(ADDR_WINDOW_LEN, data);
      check_window(length);
   endtask

   // main sequence
   initial begin
      logic signed [15:0] directed [] = '{
         16'hfff9, 16'h0000,                           // negative mean truncates toward zero
         16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
         16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
         16'hffff, 16'h0001, 16'hffff, 16'h0002, 16'hfffe, 16'h0003,
         16'h5555, 16'haaaa};

      quiet       = 1'b0;
      mean_count  = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window of five, directed samples first
      check_window(WINDOW_RESET);
      foreach (directed[i]) send_sample(directed[i]);
      send_items(100);

      set_window(5'd1);
      send_items(140);

      // full window, no random idling on either side
      set_window(5'd16);
      quiet = 1'b1;
      send_items(160);
      wait_idle();
      quiet = 1'b0;

      // zero acts as one, out-of-range values clamp to the maximum
      set_window(5'd0);
      send_items(120);
      set_window(5'd31);
      send_items(120);

      // write to an unused address leaves the history alone
      wait_idle();
      csr_write(ADDR_SPARE, $urandom);
      check_window(5'd31);
      send_items(60);

      set_window(5'd17);
      send_items(120);
      set_window(5'd2);
      send_items(120);
      set_window(5'($urandom_range(15, 3)));
      send_items(120);
      set_window(5'($urandom_range(15, 3)));
      send_items(100);

      // drain
      @(posedge clock);
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending_means.size() != 0) begin
         $error("average_out: %0d responses never arrived", sb.pending_means.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("moving_average_filter_unit: match");
      end else begin
         $display("moving_average_filter_unit: mismatch");
      end
      $finish;
   end

endmodule
